[sv/lsf_pkg.sv]
// Shared types, constants and helpers of the line substring filter.
// Used by lsf_front, lsf_queue, lsf_back and line_substring_filter.
package lsf_pkg;

	localparam int BYTE_W       = 8;
	localparam int COUNT_W      = 32;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int LEN_CFG_W    = 5;
	// Bytes held by the two pattern registers together.
	localparam int PAT_REG_BYTES = 16;
	localparam int OUT_TDATA_W  = 72;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QUEUE_PTR_W  = 2;
	localparam int QUEUE_CNT_W  = 3;

	localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
	localparam logic [BYTE_W-1:0] UPPER_FIRST  = 8'h41;
	localparam logic [BYTE_W-1:0] UPPER_LAST   = 8'h5A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_PATTERN_LENGTH = 3'd2,
		REG_IGNORE_CASE    = 3'd3,
		REG_INVERT_SELECT  = 3'd4,
		REG_COUNT_ONLY     = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [CFG_W-1:0]     pattern_low;
		logic [CFG_W-1:0]     pattern_high;
		logic [LEN_CFG_W-1:0] pattern_length;
		logic                 ignore_case;
		logic                 invert_select;
		logic                 count_only;
	} lsf_cfg_t;

	// One line end, handed from the front to the back.
	typedef struct packed {
		logic matched;
		logic last;
	} lsf_evt_t;

	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] b,
		input logic ic);
		logic [BYTE_W-1:0] r;
		r = b;
		if (ic && b >= UPPER_FIRST && b <= UPPER_LAST) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

endpackage

[sv/lsf_front.sv]
// Front end of the line substring filter: byte window, parallel pattern compare
// and line-end detection. Depends on lsf_pkg.
module lsf_front
	import lsf_pkg::*;
#(
	parameter int PATTERN_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lsf_cfg_t          cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              in_last,
	input  logic              queue_full,
	output logic              evt_push,
	output lsf_evt_t          evt
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int CMP_W = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;

	logic [BYTE_W-1:0] recent_q [PATTERN_MAX];
	logic [BYTE_W-1:0] win_new  [PATTERN_MAX];
	logic [BYTE_W-1:0] pat      [PATTERN_MAX];
	logic [BYTE_W-1:0] pat_al   [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] lane_eq;
	logic [LEN_W-1:0] bil_q, bil_new, len_eff;
	logic [CMP_W-1:0] len_wide;
	logic [2*CFG_W-1:0] pat_bits;
	logic hit_q, hit_now, line_hit, accept, line_end;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign line_end = (in_byte == NEWLINE_CODE) || in_last;
	assign pat_bits = {cfg.pattern_high, cfg.pattern_low};

	always_comb begin
		len_wide = CMP_W'(cfg.pattern_length);
		if (len_wide > CMP_W'(PATTERN_MAX)) begin
			len_wide = CMP_W'(PATTERN_MAX);
		end
		len_eff = len_wide[LEN_W-1:0];
	end

	assign bil_new = (bil_q == LEN_W'(PATTERN_MAX)) ? bil_q : bil_q + LEN_W'(1);

	genvar k;
	generate
		for (k = 0; k < PATTERN_MAX; k++) begin : g_lane
			// Pattern bytes past the two registers read as zero.
			if (k < PAT_REG_BYTES) begin : g_reg
				assign pat[k] = pat_bits[BYTE_W*k +: BYTE_W];
			end else begin : g_zero
				assign pat[k] = '0;
			end

			if (k == 0) begin : g_head
				assign win_new[k] = in_byte;
			end else begin : g_tail
				assign win_new[k] = recent_q[k-1];
			end

			// Lane k meets pattern byte len-1-k; lanes at or past len always agree.
			always_comb begin
				pat_al[k] = '0;
				for (int j = 0; j < PATTERN_MAX; j++) begin
					if (k + j + 1 == int'(len_eff)) begin
						pat_al[k] = pat[j];
					end
				end
			end

			assign lane_eq[k] = (k >= int'(len_eff)) ||
				(fold(win_new[k], cfg.ignore_case) == fold(pat_al[k], cfg.ignore_case));
		end
	endgenerate

	assign hit_now  = (len_eff == '0) || ((bil_new >= len_eff) && (&lane_eq));
	assign line_hit = hit_q || hit_now;

	assign evt_push    = accept && line_end;
	assign evt.matched = line_hit;
	assign evt.last    = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bil_q <= '0;
			hit_q <= 1'b0;
			for (int i = 0; i < PATTERN_MAX; i++) begin
				recent_q[i] <= '0;
			end
		end else if (accept) begin
			if (line_end) begin
				bil_q <= '0;
				hit_q <= 1'b0;
			end else begin
				bil_q <= bil_new;
				hit_q <= line_hit;
			end
			// The window runs across newlines; only the end of the stream clears it.
			for (int i = 0; i < PATTERN_MAX; i++) begin
				recent_q[i] <= in_last ? '0 : win_new[i];
			end
		end
	end

endmodule

[sv/lsf_queue.sv]
// Short queue of line-end events between front and back.
// Depends on lsf_pkg.
module lsf_queue
	import lsf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lsf_evt_t               push_evt,
	input  logic                   pop,
	output lsf_evt_t               head,
	output logic                   empty,
	output logic                   full,
	output logic [QUEUE_CNT_W-1:0] count
);

	lsf_evt_t mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	assign count = cnt_q;
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

[sv/lsf_back.sv]
// Back end of the line substring filter: line and match counters and the
// result register. Depends on lsf_pkg.
module lsf_back
	import lsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lsf_cfg_t           cfg,
	input  logic               q_empty,
	input  lsf_evt_t           q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COUNT_W-1:0] out_line_number,
	output logic               out_line_matched,
	output logic               out_line_selected,
	output logic [COUNT_W-1:0] out_matching_lines,
	output logic               out_stream_done
);

	logic [COUNT_W-1:0] line_cnt_q, hit_cnt_q, line_next, hit_next;
	logic valid_q;

	assign out_valid = valid_q;
	assign q_pop     = !q_empty && (!valid_q || out_ready);
	assign line_next = sat_inc(line_cnt_q);
	assign hit_next  = q_head.matched ? sat_inc(hit_cnt_q) : hit_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			line_cnt_q <= '0;
			hit_cnt_q  <= '0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			if (q_pop) begin
				// Counters start over after the last line of a stream.
				line_cnt_q <= q_head.last ? '0 : line_next;
				hit_cnt_q  <= q_head.last ? '0 : hit_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_line_number    <= line_next;
			out_line_matched   <= q_head.matched;
			out_line_selected  <= !cfg.count_only && (q_head.matched ^ cfg.invert_select);
			out_matching_lines <= hit_next;
			out_stream_done    <= q_head.last;
		end
	end

endmodule

[sv/line_substring_filter.sv]
// Top level of the line substring filter: configuration registers, front end,
// event queue and back end. Depends on lsf_pkg, lsf_front, lsf_queue, lsf_back.

// Takes one text byte per transfer and reports each line that ends, at a
// newline or at the byte marked tlast, with its number, whether it holds the
// configured pattern, whether it is selected, and the running match count.
// A byte is taken every clock cycle while the four-entry line-end queue has
// room; the whole byte window is compared with the pattern in the cycle the
// byte arrives, so with room in the queue the rate is one byte per cycle. A
// result goes through the line-end queue and then the result register once
// the byte ending its line is taken, and waits if the output side stalls.
// Configuration must be written while idle; the block does not enforce it.
module line_substring_filter
	import lsf_pkg::*;
#(
	parameter int PATTERN_MAX = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] text_byte
	input  logic                   s_axis_tlast,   // final_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [31:0] line_number, [32] line_matched, [33] line_selected,
	// [65:34] matching_lines, [71:66] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast    // stream_done
);

	lsf_cfg_t cfg_q;
	lsf_evt_t push_evt, q_head;
	logic push, pop, q_empty, q_full;
	logic [QUEUE_CNT_W-1:0] q_count;
	logic [COUNT_W-1:0] line_number, matching_lines;
	logic line_matched, line_selected;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg_data;
				REG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg_data;
				REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_data[LEN_CFG_W-1:0];
				REG_IGNORE_CASE:    cfg_q.ignore_case    <= cfg_data[0];
				REG_INVERT_SELECT:  cfg_q.invert_select  <= cfg_data[0];
				REG_COUNT_ONLY:     cfg_q.count_only     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lsf_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.queue_full(q_full),
		.evt_push  (push),
		.evt       (push_evt)
	);

	lsf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_evt(push_evt),
		.pop     (pop),
		.head    (q_head),
		.empty   (q_empty),
		.full    (q_full),
		.count   (q_count)
	);

	lsf_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.q_empty           (q_empty),
		.q_head            (q_head),
		.q_pop             (pop),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_line_number   (line_number),
		.out_line_matched  (line_matched),
		.out_line_selected (line_selected),
		.out_matching_lines(matching_lines),
		.out_stream_done   (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b0, matching_lines, line_selected, line_matched, line_number};

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("line-end queue count out of range");

	a_line_end_push: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready &&
		(s_axis_tlast || s_axis_tdata == NEWLINE_CODE)) |-> push)
		else $error("line end transfer did not reach the queue");

	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_axis_tvalid)
		else $error("queue pop produced no result");

	a_hits_within_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (matching_lines <= line_number))
		else $error("match count exceeds line count");

endmodule
